// ===== sv/fraction_reducer_assert.svh =====
// ----------------------------------------------------------------------------
// Fraction reducer assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_ASSERT_SVH
`define FRACTION_REDUCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/frac_red_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer package
// Command and status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package frac_red_pkg;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_load_num;
    logic div_load_den;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_num;
    logic zero_den;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

// ===== sv/frac_red_dp.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer datapath
// Binary GCD step unit, shared restoring divider and result registers.
// ----------------------------------------------------------------------------
module frac_red_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic [DATA_WIDTH-1:0]   in_num_i,
  input  logic [DATA_WIDTH-2:0]   in_den_i,
  input  frac_red_pkg::cmd_t      cmd_i,
  output frac_red_pkg::sts_t      sts_o,
  output logic [DATA_WIDTH-1:0]   res_num_o,
  output logic [DATA_WIDTH-2:0]   res_den_o,
  output logic [DATA_WIDTH-2:0]   res_gcd_o,
  output logic                    res_zd_o
);
  import frac_red_pkg::*;

  localparam int CntW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] num_q, num_d;
  logic [DATA_WIDTH-2:0] den_q, den_d;
  logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [CntW-1:0]       k_q, k_d, cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] g_q, g_d, dvd_q, dvd_d, rem_q, rem_d, qnum_q, qnum_d;
  logic [DATA_WIDTH-1:0] res_num_q, res_num_d;
  logic [DATA_WIDTH-2:0] res_den_q, res_den_d, res_gcd_q, res_gcd_d;
  logic                  res_zd_q, res_zd_d;

  logic [DATA_WIDTH-1:0] mag_in, mag_q, diff_ab, diff_ba, rem_sh;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  fits;

  assign mag_in  = in_num_i[DATA_WIDTH-1] ? ('0 - in_num_i) : in_num_i;
  assign mag_q   = num_q[DATA_WIDTH-1] ? ('0 - num_q) : num_q;
  assign diff_ab = a_q - b_q;
  assign diff_ba = b_q - a_q;
  assign rem_sh  = {rem_q[DATA_WIDTH-2:0], dvd_q[DATA_WIDTH-1]};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, g_q};
  assign fits    = ~rem_sub[DATA_WIDTH];

  always_comb begin
    num_d     = num_q;
    den_d     = den_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    g_d       = g_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    qnum_d    = qnum_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    res_gcd_d = res_gcd_q;
    res_zd_d  = res_zd_q;

    if (cmd_i.load) begin
      num_d = in_num_i;
      den_d = in_den_i;
      a_d   = mag_in;
      b_d   = {1'b0, in_den_i};
      k_d   = '0;
    end

    if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + CntW'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = diff_ab >> 1;
      end else begin
        b_d = diff_ba >> 1;
      end
    end

    if (cmd_i.div_load_num) begin
      g_d   = a_q << k_q;
      dvd_d = mag_q;
      rem_d = '0;
      cnt_d = '0;
    end

    if (cmd_i.div_load_den) begin
      qnum_d = dvd_q;
      dvd_d  = {1'b0, den_q};
      rem_d  = '0;
      cnt_d  = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = fits ? rem_sub[DATA_WIDTH-1:0] : rem_sh;
      dvd_d = {dvd_q[DATA_WIDTH-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
    end

    if (cmd_i.out_load) begin
      if (den_q == '0) begin
        res_num_d = num_q;
        res_den_d = '0;
        res_gcd_d = '0;
        res_zd_d  = 1'b1;
      end else if (num_q == '0) begin
        res_num_d = '0;
        res_den_d = (DATA_WIDTH-1)'(1);
        res_gcd_d = den_q;
        res_zd_d  = 1'b0;
      end else begin
        res_num_d = num_q[DATA_WIDTH-1] ? ('0 - qnum_q) : qnum_q;
        res_den_d = dvd_q[DATA_WIDTH-2:0];
        res_gcd_d = g_q[DATA_WIDTH-2:0];
        res_zd_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    den_q     <= den_d;
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    g_q       <= g_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    qnum_q    <= qnum_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_gcd_q <= res_gcd_d;
    res_zd_q  <= res_zd_d;
  end

  assign sts_o.zero_num = (num_q == '0);
  assign sts_o.zero_den = (den_q == '0);
  assign sts_o.gcd_done = (a_q == b_q);
  assign sts_o.div_last = (cnt_q == CntW'(DATA_WIDTH - 1));

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign res_gcd_o = res_gcd_q;
  assign res_zd_o  = res_zd_q;

endmodule

// ===== sv/frac_red_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer controller
// Sequences the GCD search, both divisions and the output handshake.
// ----------------------------------------------------------------------------
module frac_red_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic                m_ready_i,
  output logic                m_valid_o,
  input  frac_red_pkg::sts_t  sts_i,
  output frac_red_pkg::cmd_t  cmd_o
);
  import frac_red_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_GCD      = 6'b000010,
    ST_DIV_NUM  = 6'b000100,
    ST_LOAD_DEN = 6'b001000,
    ST_DIV_DEN  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts_i.zero_den || sts_i.zero_num) begin
          state_d = ST_DONE;
        end else if (sts_i.gcd_done) begin
          cmd.div_load_num = 1'b1;
          state_d          = ST_DIV_NUM;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV_NUM: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_LOAD_DEN;
        end
      end
      ST_LOAD_DEN: begin
        cmd.div_load_den = 1'b1;
        state_d          = ST_DIV_DEN;
      end
      ST_DIV_DEN: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!valid_q || m_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (valid_q && m_ready_i) begin
      valid_d = 1'b0;
    end
    if (cmd.out_load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = valid_q;
  assign cmd_o     = cmd;

endmodule

// ===== sv/fraction_reducer.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer
// Reduces a signed fraction to lowest terms and reports the common divisor.
// ----------------------------------------------------------------------------
// Each input beat carries a numerator and a denominator; each output beat
// carries the reduced numerator, reduced denominator and common divisor in
// tdata, and the zero-denominator flag in tuser.
// One fraction is processed at a time. After an input beat is accepted, a
// binary GCD runs, followed by two divisions on one shared restoring divider.
// A zero numerator or a zero denominator skips the GCD and division.
// The GCD loop and the shared divider set the item time.
// The result sits in an output register, so the next input beat is taken
// while it waits. If the receiver stalls, the finished result is held
// and the following one waits in the datapath until the register frees.
// Reset clears the controller and the output valid; nothing else needs it.
// ----------------------------------------------------------------------------
module fraction_reducer #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // numerator, denominator
  input  logic [((2*DATA_WIDTH-1+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // reduced_numerator, reduced_denominator, common_divisor
  output logic [((3*DATA_WIDTH-2+7)/8)*8-1:0]     m_axis_tdata_o,
  // zero_denominator
  output logic                                    m_axis_tuser_o
);
  import frac_red_pkg::*;

  localparam int OutW = ((3*DATA_WIDTH-2+7)/8)*8;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [DATA_WIDTH-1:0] res_num;
  logic [DATA_WIDTH-2:0] res_den;
  logic [DATA_WIDTH-2:0] res_gcd;
  logic                  res_zd;

  frac_red_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  frac_red_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .in_num_i  (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .in_den_i  (s_axis_tdata_i[2*DATA_WIDTH-2:DATA_WIDTH]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_num_o (res_num),
    .res_den_o (res_den),
    .res_gcd_o (res_gcd),
    .res_zd_o  (res_zd)
  );

  assign m_axis_tdata_o = OutW'({res_gcd, res_den, res_num});
  assign m_axis_tuser_o = res_zd;

endmodule

// ===== sv/fraction_reducer_checker.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "fraction_reducer_assert.svh"

module fraction_reducer_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [((3*DATA_WIDTH-2+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                                m_axis_tuser_o
);

  logic [DATA_WIDTH-2:0] out_den;
  logic [DATA_WIDTH-2:0] out_gcd;

  assign out_den = m_axis_tdata_o[2*DATA_WIDTH-2:DATA_WIDTH];
  assign out_gcd = m_axis_tdata_o[3*DATA_WIDTH-3:2*DATA_WIDTH-1];

  `FR_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "output beat changed while stalled")

  `FR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input taken while a fraction is in work")

  `FR_ASSERT_IMPL(a_zero_den_fields, m_axis_tvalid_o && m_axis_tuser_o, out_den == '0 && out_gcd == '0, "zero-denominator beat with nonzero fields")

  `FR_ASSERT_IMPL(a_nonzero_fields, m_axis_tvalid_o && !m_axis_tuser_o, out_den != '0 && out_gcd != '0, "reduced beat with zero denominator or divisor")

endmodule

bind fraction_reducer fraction_reducer_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_checker (.*);

// ===== tb/sv/fraction_reducer_tb.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer testbench
// Sends signed fractions into the block and checks each reduced fraction, the
// common divisor and the zero-denominator flag against a predictor computed
// here. A directed set covers the extremes and the special cases, and a large
// random set follows. Both sides of the stream idle in random bursts. One
// phase holds the output off long enough to back the input up, and another
// pauses the input until every result is back. The run ends with a
// back-to-back phase with no idling.
// ----------------------------------------------------------------------------
module fraction_reducer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW             = 32;
  localparam int IN_W           = ((2*DW-1+7)/8)*8;
  localparam int OUT_W          = ((3*DW-2+7)/8)*8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 200;

  typedef struct packed {
    logic [DW-1:0] numerator;
    logic [DW-2:0] denominator;
    logic [DW-2:0] divisor;
    logic          zero_den;
  } fraction_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tuser_o;

  fraction_t pending_fractions[$];
  int        mismatch_count;
  int        stuck_cycles;
  logic      idle_en;
  logic      holdoff_req;

  fraction_reducer #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fraction_t reduce_fraction(input logic [DW-1:0] num,
                                                input logic [DW-2:0] den);
    fraction_t     res;
    logic [DW-1:0] mag;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] r;
    logic [DW-1:0] q;
    res = '0;
    mag = num[DW-1] ? (~num + 1'b1) : num;
    if (den == '0) begin
      res.numerator = num;
      res.zero_den  = 1'b1;
    end else if (mag == '0) begin
      res.denominator = (DW-1)'(1);
      res.divisor     = den;
    end else begin
      a = mag;
      b = {1'b0, den};
      while (b != '0) begin
        r = a % b;
        a = b;
        b = r;
      end
      q = mag / a;
      res.numerator   = num[DW-1] ? (~q + 1'b1) : q;
      res.denominator = (DW-1)'(den / a);
      res.divisor     = a[DW-2:0];
    end
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_fraction(input logic [DW-1:0] num, input logic [DW-2:0] den);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'({den, num});
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_fractions.push_back(reduce_fraction(num, den));
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_fractions.size() != 0);
  endtask

  task automatic send_random_fraction();
    logic [DW-1:0] num;
    logic [DW-2:0] den;
    int unsigned   g;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        num = $urandom;
        den = (DW-1)'($urandom);
      end
      3, 4, 5: begin
        g   = $urandom_range(1, 65535);
        num = $urandom_range(0, 32767) * g;
        den = (DW-1)'($urandom_range(1, 32767) * g);
      end
      6: begin
        num = 1 << $urandom_range(0, DW-1);
        den = (DW-1)'(1) << $urandom_range(0, DW-2);
      end
      7: begin
        num = $urandom_range(0, 40);
        den = (DW-1)'($urandom_range(0, 40));
      end
      8: begin
        den = (DW-1)'($urandom);
        num = {1'b0, den} >> $urandom_range(0, 4);
      end
      default: begin
        num = $urandom_range(0, 1) ? '0 : $urandom;
        den = (num != '0) ? '0 : $urandom_range(0, 1) ? '0 : (DW-1)'($urandom);
      end
    endcase
    if (num != {1'b1, {(DW-1){1'b0}}} && $urandom_range(0, 1) == 1) begin
      num = -num;
    end
    send_fraction(num, den);
  endtask

  task automatic test_directed();
    send_fraction(32'd0, 31'd1);
    send_fraction(32'd0, 31'h7FFF_FFFF);
    send_fraction(32'd5, 31'd0);
    send_fraction(-32'sd7, 31'd0);
    send_fraction(32'd0, 31'd0);
    send_fraction(32'h8000_0000, 31'd0);
    send_fraction(32'h7FFF_FFFF, 31'd1);
    send_fraction(-32'sd2147483647, 31'd1);
    send_fraction(32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_fraction(-32'sd2147483647, 31'h7FFF_FFFF);
    send_fraction(32'h8000_0000, 31'd1);
    send_fraction(32'h8000_0000, 31'd3);
    send_fraction(32'h8000_0000, 31'h4000_0000);
    send_fraction(32'h8000_0000, 31'h7FFF_FFFF);
    send_fraction(32'd12, 31'd18);
    send_fraction(-32'sd12, 31'd18);
    send_fraction(32'd30, 31'd6);
    send_fraction(-32'sd1, 31'd1);
    send_fraction(32'd1, 31'd1);
    send_fraction(32'h7FFF_FFFE, 31'h3FFF_FFFF);
    send_fraction(32'h5555_5555, 31'h2AAA_AAAA);
    send_fraction(32'hAAAA_AAAA, 31'h5555_5555);
  endtask

  task automatic test_random_fractions(input int count);
    repeat (count) send_random_fraction();
  endtask

  task automatic test_output_stall();
    idle_en     = 1'b0;
    holdoff_req = 1'b1;
    repeat (12) send_random_fraction();
    idle_en     = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (10) send_random_fraction();
    pause_until_drained();
    repeat (10) send_random_fraction();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (40) send_random_fraction();
  endtask

  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    fraction_t got;
    fraction_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.numerator   = m_axis_tdata_o[DW-1:0];
        got.denominator = m_axis_tdata_o[2*DW-2:DW];
        got.divisor     = m_axis_tdata_o[3*DW-3:2*DW-1];
        got.zero_den    = m_axis_tuser_o;
        if (pending_fractions.size() == 0) begin
          $error("unexpected result beat: tdata %h, tuser %b", m_axis_tdata_o, m_axis_tuser_o);
          mismatch_count++;
        end else begin
          want = pending_fractions.pop_front();
          if (got.numerator !== want.numerator) begin
            $error("reduced_numerator: expected %h, got %h", want.numerator, got.numerator);
            mismatch_count++;
          end
          if (got.denominator !== want.denominator) begin
            $error("reduced_denominator: expected %h, got %h",
                   want.denominator, got.denominator);
            mismatch_count++;
          end
          if (got.divisor !== want.divisor) begin
            $error("common_divisor: expected %h, got %h", want.divisor, got.divisor);
            mismatch_count++;
          end
          if (got.zero_den !== want.zero_den) begin
            $error("zero_denominator: expected %b, got %b", want.zero_den, got.zero_den);
            mismatch_count++;
          end
        end
      end
      if (stuck_cycles >= QUIET_LIMIT) begin
        $error("no beat moved for %0d cycles, %0d results outstanding",
               stuck_cycles, pending_fractions.size());
        $display("fraction_reducer_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    idle_en         = 1'b1;
    holdoff_req     = 1'b0;
    mismatch_count  = 0;
    stuck_cycles    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_fractions(560);
    test_output_stall();
    test_drain_pause();
    test_back_to_back();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_fractions.size() == 0) begin
      $display("fraction_reducer_tb: done, clean");
    end else begin
      $display("fraction_reducer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/frac_red_pkg.sv
sv/frac_red_dp.sv
sv/frac_red_ctrl.sv
sv/fraction_reducer.sv
sv/fraction_reducer_checker.sv
tb/sv/fraction_reducer_tb.sv
